FILE: src/slc_pkg.sv
package slc_pkg;

  localparam int LINE_BYTES_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int ADDR_W          = 48;
  localparam int IDX_W           = 32;
  localparam int EB_W            = 10;

  localparam logic [1:0] REG_ELEMENT_BYTES   = 2'd0;
  localparam logic [1:0] REG_COALESCE_ENABLE = 2'd1;
  localparam logic [1:0] REG_TRIP_COUNT      = 2'd2;

  typedef struct packed {
    logic load;
    logic seal;
    logic scan_step;
    logic alloc_step;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic do_coalesce;
    logic lo_below;
    logic scan_done;
    logic alloc_done;
    logic can_pop;
  } sts_t;

endpackage

FILE: src/slc_if.sv
interface slc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [slc_pkg::ADDR_W-1:0]  element_address;
  modport source (output valid, mode, element_address, input ready);
  modport sink (input valid, mode, element_address, output ready);
endinterface

interface slc_out_if;
  logic                        valid;
  logic                        ready;
  logic [slc_pkg::ADDR_W-1:0]  line_address;
  logic [slc_pkg::IDX_W-1:0]   first_element;
  logic [slc_pkg::IDX_W-1:0]   end_element;
  logic                        last;
  modport source (output valid, line_address, first_element, end_element, last,
                  input ready);
  modport sink (input valid, line_address, first_element, end_element, last,
                output ready);
endinterface

FILE: src/slc_datapath.sv
module slc_datapath #(
  parameter int LINE_BYTES  = slc_pkg::LINE_BYTES_DEF,
  parameter int QUEUE_DEPTH = slc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slc_pkg::cmd_t              cmd,
  output slc_pkg::sts_t              sts,
  input  logic                       in_mode,
  input  logic [slc_pkg::ADDR_W-1:0] in_addr,
  input  logic [slc_pkg::EB_W-1:0]   element_bytes,
  input  logic                       coalesce_enable,
  input  logic [slc_pkg::IDX_W-1:0]  trip_count,
  output logic [slc_pkg::ADDR_W-1:0] pop_line,
  output logic [slc_pkg::IDX_W-1:0]  pop_first,
  output logic [slc_pkg::IDX_W-1:0]  pop_end,
  output logic                       pop_last
);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(LINE_BYTES);
  localparam int AW = slc_pkg::ADDR_W;
  localparam int IW = slc_pkg::IDX_W;
  localparam int RW = $clog2(slc_pkg::MAX_RESULTS + 1);

  logic [AW-1:0] sl_line [QUEUE_DEPTH];
  logic [IW-1:0] sl_first [QUEUE_DEPTH];
  logic [IW-1:0] sl_end [QUEUE_DEPTH];

  logic [QW-1:0] head_r;
  logic [QW:0]   count_r;
  logic [IW-1:0] next_index_r, seal_index_r;
  logic [AW-1:0] prev_line_r;
  logic [AW-1:0] lo_r, hi_r, cur_r;
  logic          mode_r, coal_r, cur_ovf_r, scan_hit_end_r;
  logic [QW:0]   scan_i_r;
  logic [RW-1:0] nres_r;

  logic [AW:0]   last_byte;
  logic [AW-1:0] last_sat, lo_line, hi_line;
  logic [AW:0]   cur_inc;
  logic [QW-1:0] scan_slot, tail_slot;

  always_comb begin
    last_byte = {1'b0, in_addr} + {{(AW+1-slc_pkg::EB_W){1'b0}},
                (element_bytes == '0) ? {{(slc_pkg::EB_W-1){1'b0}}, 1'b1}
                                      : element_bytes} - (AW+1)'(1);
    last_sat  = last_byte[AW] ? {AW{1'b1}} : last_byte[AW-1:0];
    lo_line   = {in_addr[AW-1:LW], {LW{1'b0}}};
    hi_line   = {last_sat[AW-1:LW], {LW{1'b0}}};
    cur_inc   = {1'b0, cur_r} + (AW+1)'(LINE_BYTES);
    scan_slot = head_r + scan_i_r[QW-1:0];
    tail_slot = head_r + count_r[QW-1:0];
  end

  // status
  always_comb begin
    sts.do_coalesce = coal_r;
    sts.lo_below    = lo_r < ((next_index_r != '0) ? prev_line_r : lo_r);
    sts.scan_done   = (scan_i_r == count_r) || scan_hit_end_r;
    sts.alloc_done  = cur_ovf_r || (cur_r > hi_r);
    sts.can_pop     = (count_r != '0) && (nres_r != RW'(slc_pkg::MAX_RESULTS)) &&
                      (mode_r || (sl_end[head_r] != next_index_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; count_r <= '0; next_index_r <= '0; seal_index_r <= '0;
      prev_line_r <= '0; nres_r <= '0;
    end else begin
      if (cmd.load) begin
        nres_r <= '0;
        scan_i_r <= '0;
        scan_hit_end_r <= 1'b0;
        mode_r <= in_mode;
        lo_r <= lo_line;
        hi_r <= hi_line;
        cur_r <= lo_line;
        cur_ovf_r <= 1'b0;
        coal_r <= coalesce_enable &&
                  (trip_count == '0 || next_index_r < trip_count);
      end
      if (cmd.seal) seal_index_r <= next_index_r;
      if (cmd.scan_step) begin
        scan_i_r <= scan_i_r + 1'b1;
        if (sl_first[scan_slot] >= seal_index_r && sl_line[scan_slot] == cur_r) begin
          sl_end[scan_slot] <= sl_end[scan_slot] + 1'b1;
          cur_r <= cur_inc[AW-1:0];
          cur_ovf_r <= cur_inc[AW];
          if (cur_inc[AW] || cur_inc[AW-1:0] > hi_r) scan_hit_end_r <= 1'b1;
        end
      end
      if (cmd.alloc_step) begin
        if (count_r != (QW+1)'(QUEUE_DEPTH)) begin
          sl_line[tail_slot]  <= cur_r;
          sl_first[tail_slot] <= next_index_r;
          sl_end[tail_slot]   <= next_index_r + 1'b1;
          count_r <= count_r + 1'b1;
        end
        cur_r <= cur_inc[AW-1:0];
        cur_ovf_r <= cur_inc[AW];
      end
      if (cmd.finish) begin
        prev_line_r <= lo_r;
        next_index_r <= next_index_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r <= head_r + 1'b1;
        count_r <= count_r - 1'b1;
        nres_r <= nres_r + 1'b1;
      end
    end
  end

  // last is known when the following slice cannot go out
  logic [QW-1:0] nxt_slot;
  assign nxt_slot  = head_r + 1'b1;
  assign pop_line  = sl_line[head_r];
  assign pop_first = sl_first[head_r];
  assign pop_end   = sl_end[head_r];
  assign pop_last  = (count_r == (QW+1)'(1)) ||
                     (nres_r == RW'(slc_pkg::MAX_RESULTS - 1)) ||
                     (!mode_r && sl_end[nxt_slot] == next_index_r);

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QW+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pop && count_r == '0)) else $error("pop from empty queue");
  a_scan_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.alloc_step && cmd.scan_step)) else $error("scan and alloc overlap");
endmodule

FILE: src/slc_ctrl.sv
module slc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_mode,
  output logic          out_valid,
  input  logic          out_ready,
  input  slc_pkg::sts_t sts,
  output slc_pkg::cmd_t cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_FIN   = 6'b010000,
    S_POP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) mode_r <= in_mode;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode ? S_POP : S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.do_coalesce || sts.lo_below) begin
          cmd.seal  = 1'b1;
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_ALLOC;
        else cmd.scan_step = 1'b1;
      end
      S_ALLOC: begin
        if (sts.alloc_done) state_nxt = S_FIN;
        else cmd.alloc_step = 1'b1;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_POP;
      end
      S_POP: begin
        if (!sts.can_pop) begin
          state_nxt = S_IDLE;
        end else begin
          out_valid = 1'b1;
          if (out_ready) cmd.pop = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready)) else $error("output while accepting");
  a_flush_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.finish && mode_r)) else $error("flush advanced index");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
endmodule

FILE: src/stream_line_slice_coalescer.sv
// Channel | Dir | Payload
// in_     | in  | mode, element_address
// out_    | out | line_address, first_element, end_element, last
// cfg_    | in  | APB: element_bytes @0, coalesce_enable @4, trip_count @8
//
// Sequence: an element passes decode, a scan of the queued slices when it
// coalesces, line allocation, finish and emission; a flush goes straight to emission.
// Reset: rst_n synchronous, active low; queue empties, registers to defaults.
// Stalls: out_ready low holds the emitting slice; no input is taken meanwhile.
module stream_line_slice_coalescer #(
  parameter int LINE_BYTES  = slc_pkg::LINE_BYTES_DEF,
  parameter int QUEUE_DEPTH = slc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  slc_in_if.sink      in_ch,
  slc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  slc_pkg::cmd_t cmd;
  slc_pkg::sts_t sts;

  logic [slc_pkg::EB_W-1:0]  element_bytes_r;
  logic                      coalesce_enable_r;
  logic [slc_pkg::IDX_W-1:0] trip_count_r;

  assign cfg_pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_bytes_r   <= slc_pkg::EB_W'(8);
      coalesce_enable_r <= 1'b1;
      trip_count_r      <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        slc_pkg::REG_ELEMENT_BYTES:   element_bytes_r   <= cfg_pwdata[slc_pkg::EB_W-1:0];
        slc_pkg::REG_COALESCE_ENABLE: coalesce_enable_r <= cfg_pwdata[0];
        slc_pkg::REG_TRIP_COUNT:      trip_count_r      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      slc_pkg::REG_ELEMENT_BYTES:
        cfg_prdata = {{(32-slc_pkg::EB_W){1'b0}}, element_bytes_r};
      slc_pkg::REG_COALESCE_ENABLE: cfg_prdata = {31'b0, coalesce_enable_r};
      slc_pkg::REG_TRIP_COUNT:      cfg_prdata = trip_count_r;
      default:                      cfg_prdata = '0;
    endcase
  end

  slc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_mode (in_ch.mode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  slc_datapath #(.LINE_BYTES(LINE_BYTES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_mode(in_ch.mode), .in_addr(in_ch.element_address),
    .element_bytes(element_bytes_r), .coalesce_enable(coalesce_enable_r),
    .trip_count(trip_count_r),
    .pop_line(out_ch.line_address), .pop_first(out_ch.first_element),
    .pop_end(out_ch.end_element), .pop_last(out_ch.last)
  );

  a_chan_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready)) else $error("overlap of channels");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && !in_ch.valid)) else $error("load without transaction");
  a_pop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pop && !out_ch.ready)) else $error("pop without take");
endmodule
